>>> src/rmcsr_pkg.sv
// rmcsr_pkg: command, address and status codes for the machine csr file
// no dependencies; imported by riscv_machine_csr_file
package rmcsr_pkg;

    localparam int XLEN = 64;

    typedef logic [XLEN-1:0] xword_t;
    typedef logic [11:0]     csr_addr_t;

    // command codes
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PEND  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // access status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DELEG    = 2'd1;
    localparam logic [1:0] ST_UNIMPL   = 2'd2;

    // interrupt target codes
    localparam logic [1:0] TGT_NONE    = 2'd0;
    localparam logic [1:0] TGT_MACHINE = 2'd1;
    localparam logic [1:0] TGT_SUPER   = 2'd2;
    localparam logic [1:0] TGT_USER    = 2'd3;

    // privilege levels
    localparam logic [1:0] PRIV_USER    = 2'd0;
    localparam logic [1:0] PRIV_SUPER   = 2'd2;
    localparam logic [1:0] PRIV_MACHINE = 2'd3;

    // configuration register indexes
    localparam logic CFG_MIDELEG = 1'b0;
    localparam logic CFG_SIDELEG = 1'b1;

    // csr addresses
    localparam csr_addr_t ADDR_SCOUNTEREN = 12'h106;
    localparam csr_addr_t ADDR_SATP       = 12'h180;
    localparam csr_addr_t ADDR_MSTATUS    = 12'h300;
    localparam csr_addr_t ADDR_MISA       = 12'h301;
    localparam csr_addr_t ADDR_MEDELEG    = 12'h302;
    localparam csr_addr_t ADDR_MIDELEG    = 12'h303;
    localparam csr_addr_t ADDR_MIE        = 12'h304;
    localparam csr_addr_t ADDR_MTVEC      = 12'h305;
    localparam csr_addr_t ADDR_MCOUNTEREN = 12'h306;
    localparam csr_addr_t ADDR_MSCRATCH   = 12'h340;
    localparam csr_addr_t ADDR_MHARTID    = 12'hf14;

    // pmpcfg0..3 share addr[11:2], pmpaddr0..15 share addr[11:4]
    localparam logic [9:0] PMPCFG_BASE  = 10'h0e8;
    localparam logic [7:0] PMPADDR_BASE = 8'h3b;

    localparam xword_t MISA_VALUE   = 64'h8000_0000_0014_1129;
    localparam xword_t MSTATUS_MASK = 64'h8000_000F_007F_F9BB;

    localparam int MSTATUS_MIE_BIT = 3;
    localparam int MSTATUS_SIE_BIT = 1;
    localparam int MSTATUS_UIE_BIT = 0;

endpackage

>>> src/riscv_machine_csr_file.sv
// riscv_machine_csr_file: rv64 machine csr file with interrupt pend check
// an accepted item waits in the input register and moves into the result register when that is empty or taken
// throughput: one item per cycle while results are taken; decode, update and interrupt check are one pass
// s_ready drops only when the input register is full and the result is not taken
// reset: synchronous active-low aresetn clears all csrs, delegation and both valids
// depends on rmcsr_pkg
module riscv_machine_csr_file
    import rmcsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [11:0] s_csr_address,
    input  logic [63:0] s_write_data,
    input  logic [1:0]  s_privilege_level,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_read_data,
    output logic [1:0]  m_access_status,
    output logic [1:0]  m_interrupt_target
);

    // input register
    logic      in_vld_reg;
    cmd_t      in_cmd_reg;
    csr_addr_t in_addr_reg;
    xword_t    in_data_reg;
    logic [1:0] in_priv_reg;

    // architectural state
    xword_t mideleg_reg, sideleg_reg;
    xword_t scounteren_reg, satp_reg, mstatus_reg, mie_reg;
    xword_t mtvec_reg, mcounteren_reg, mscratch_reg, mip_reg;

    // result register
    logic       out_vld_reg;
    xword_t     out_data_reg;
    logic [1:0] out_status_reg;
    logic [1:0] out_target_reg;

    logic advance;
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    assign m_valid            = out_vld_reg;
    assign m_read_data        = out_data_reg;
    assign m_access_status    = out_status_reg;
    assign m_interrupt_target = out_target_reg;

    // decode
    logic   is_rw, is_zero, is_known;
    xword_t rd_value;
    logic [1:0] acc_status;

    always_comb begin
        is_zero  = (in_addr_reg[11:2] == PMPCFG_BASE) || (in_addr_reg[11:4] == PMPADDR_BASE)
                   || (in_addr_reg == ADDR_MHARTID);
        is_known = 1'b1;
        rd_value = '0;
        unique case (in_addr_reg)
            ADDR_SCOUNTEREN: rd_value = scounteren_reg;
            ADDR_SATP:       rd_value = satp_reg;
            ADDR_MSTATUS:    rd_value = mstatus_reg;
            ADDR_MISA:       rd_value = MISA_VALUE;
            ADDR_MIE:        rd_value = mie_reg;
            ADDR_MTVEC:      rd_value = mtvec_reg;
            ADDR_MCOUNTEREN: rd_value = mcounteren_reg;
            ADDR_MSCRATCH:   rd_value = mscratch_reg;
            default:         is_known = is_zero;
        endcase
        priority if (in_addr_reg == ADDR_MEDELEG || in_addr_reg == ADDR_MIDELEG) begin
            acc_status = ST_DELEG;
        end else if (is_known) begin
            acc_status = ST_OK;
        end else begin
            acc_status = ST_UNIMPL;
        end
        is_rw = (in_cmd_reg == CMD_READ) || (in_cmd_reg == CMD_WRITE);
    end

    // interrupt check against the pending value after the pend
    xword_t mip_or, act;
    logic   m_en, s_en, u_en;
    logic [1:0] target;

    always_comb begin
        mip_or = mip_reg | in_data_reg;
        act    = mie_reg & mip_or;
        m_en   = (in_priv_reg != PRIV_MACHINE) || mstatus_reg[MSTATUS_MIE_BIT];
        // the reserved level counts as below supervisor
        s_en   = (in_priv_reg < PRIV_SUPER)
                 || ((in_priv_reg == PRIV_SUPER) && mstatus_reg[MSTATUS_SIE_BIT]);
        u_en   = (in_priv_reg == PRIV_USER) && mstatus_reg[MSTATUS_UIE_BIT];
        priority if (m_en && ((act & ~mideleg_reg) != '0)) begin
            target = TGT_MACHINE;
        end else if (s_en && ((act & mideleg_reg & ~sideleg_reg) != '0)) begin
            target = TGT_SUPER;
        end else if (u_en && ((act & mideleg_reg & sideleg_reg) != '0)) begin
            target = TGT_USER;
        end else begin
            target = TGT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_cmd_reg  <= cmd_t'(s_command);
            in_addr_reg <= s_csr_address;
            in_data_reg <= s_write_data;
            in_priv_reg <= s_privilege_level;
        end
    end

    logic do_write;
    assign do_write = advance && (in_cmd_reg == CMD_WRITE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mideleg_reg    <= '0;
            sideleg_reg    <= '0;
            scounteren_reg <= '0;
            satp_reg       <= '0;
            mstatus_reg    <= '0;
            mie_reg        <= '0;
            mtvec_reg      <= '0;
            mcounteren_reg <= '0;
            mscratch_reg   <= '0;
            mip_reg        <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MIDELEG: mideleg_reg <= cfg_wdata;
                    CFG_SIDELEG: sideleg_reg <= cfg_wdata;
                    default:     ;
                endcase
            end
            if (do_write) begin
                unique case (in_addr_reg)
                    ADDR_SCOUNTEREN: scounteren_reg <= in_data_reg;
                    ADDR_SATP:       satp_reg       <= in_data_reg;
                    ADDR_MSTATUS:    mstatus_reg    <= in_data_reg & MSTATUS_MASK;
                    ADDR_MIE:        mie_reg        <= in_data_reg;
                    ADDR_MTVEC:      mtvec_reg      <= in_data_reg;
                    ADDR_MCOUNTEREN: mcounteren_reg <= in_data_reg;
                    ADDR_MSCRATCH:   mscratch_reg   <= in_data_reg;
                    default:         ;
                endcase
            end
            if (advance && (in_cmd_reg == CMD_PEND)) begin
                mip_reg <= mip_or;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg   <= (in_cmd_reg == CMD_READ && acc_status == ST_OK) ? rd_value : '0;
            out_status_reg <= is_rw ? acc_status : ST_OK;
            out_target_reg <= (in_cmd_reg == CMD_PEND) ? target : TGT_NONE;
        end
    end

    // a pend never reports an access error
    a_target_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_interrupt_target != TGT_NONE) |-> (m_access_status == ST_OK))
        else $error("interrupt target with access error");

    // read data only comes with an ok status
    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_read_data != '0) |-> (m_access_status == ST_OK)
            && (m_interrupt_target == TGT_NONE))
        else $error("read data with error or target");

    // back-pressure only while both stages hold an item
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled without full pipeline");

    // a result appears only after an item reached the input register
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_vld_reg))
        else $error("result without input");

endmodule

>>> dv/testbench.sv
// testbench for riscv_machine_csr_file: csr reads and writes, interrupt pends, delegation
// compares every result against an in-order prediction; depends on rmcsr_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
    import rmcsr_pkg::*;

    typedef struct packed {
        xword_t     rdata;
        logic [1:0] status;
        logic [1:0] target;
    } csr_result_t;

    localparam int MSTATUS_SLOT = 2;
    localparam int MIE_SLOT     = 3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_MIDELEG;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    cmd_t        s_command = CMD_READ;
    logic [11:0] s_csr_address = '0;
    logic [63:0] s_write_data = '0;
    logic [1:0]  s_privilege_level = PRIV_USER;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_read_data;
    logic [1:0]  m_access_status;
    logic [1:0]  m_interrupt_target;

    // read/write registers, in the order of the predicted register array
    csr_addr_t   rw_addrs [7] = '{ADDR_SCOUNTEREN, ADDR_SATP, ADDR_MSTATUS, ADDR_MIE,
                                  ADDR_MTVEC, ADDR_MCOUNTEREN, ADDR_MSCRATCH};
    xword_t      csr_regs [7] = '{default: '0};
    xword_t      pending_bits = '0;
    xword_t      mdeleg_cfg = '0;
    xword_t      sdeleg_cfg = '0;

    csr_result_t expected_q [$];
    csr_result_t oldest;
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_len = 0;
    int          hold_left = 0;

    riscv_machine_csr_file u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_csr_address      (s_csr_address),
        .s_write_data       (s_write_data),
        .s_privilege_level  (s_privilege_level),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_read_data        (m_read_data),
        .m_access_status    (m_access_status),
        .m_interrupt_target (m_interrupt_target)
    );

    always #1 aclk = ~aclk;

    function automatic csr_result_t predict_csr_result(cmd_t cmd, csr_addr_t addr, xword_t data,
                                                       logic [1:0] priv);
        csr_result_t res;
        xword_t      active;
        int          slot;
        res = '0;
        slot = -1;
        foreach (rw_addrs[i])
            if (rw_addrs[i] == addr) slot = i;
        if (cmd == CMD_READ || cmd == CMD_WRITE) begin
            if (addr == ADDR_MEDELEG || addr == ADDR_MIDELEG) begin
                res.status = ST_DELEG;
            end else if (addr == ADDR_MISA) begin
                if (cmd == CMD_READ) res.rdata = MISA_VALUE;
            end else if (addr[11:2] == PMPCFG_BASE || addr[11:4] == PMPADDR_BASE ||
                         addr == ADDR_MHARTID) begin
                res.rdata = '0;
            end else if (slot < 0) begin
                res.status = ST_UNIMPL;
            end else if (cmd == CMD_WRITE) begin
                csr_regs[slot] = (addr == ADDR_MSTATUS) ? (data & MSTATUS_MASK) : data;
            end else begin
                res.rdata = csr_regs[slot];
            end
        end else if (cmd == CMD_PEND) begin
            pending_bits |= data;
            active = csr_regs[MIE_SLOT] & pending_bits;
            if ((priv != PRIV_MACHINE || csr_regs[MSTATUS_SLOT][MSTATUS_MIE_BIT]) &&
                |(active & ~mdeleg_cfg))
                res.target = TGT_MACHINE;
            else if ((priv < PRIV_SUPER ||
                      (priv == PRIV_SUPER && csr_regs[MSTATUS_SLOT][MSTATUS_SIE_BIT])) &&
                     |(active & mdeleg_cfg & ~sdeleg_cfg))
                res.target = TGT_SUPER;
            else if (priv == PRIV_USER && csr_regs[MSTATUS_SLOT][MSTATUS_UIE_BIT] &&
                     |(active & mdeleg_cfg & sdeleg_cfg))
                res.target = TGT_USER;
        end
        return res;
    endfunction

    function automatic xword_t pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return xword_t'(1) << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic csr_addr_t pick_address();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return rw_addrs[$urandom_range(0, 6)];
            5: return ADDR_MISA;
            6: return $urandom_range(0, 1) ? ADDR_MEDELEG : ADDR_MIDELEG;
            7: return $urandom_range(0, 1) ? {PMPCFG_BASE, 2'($urandom_range(0, 3))}
                                           : {PMPADDR_BASE, 4'($urandom_range(0, 15))};
            8: return ADDR_MHARTID;
            default: return csr_addr_t'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic report_mismatch(string what, xword_t got, xword_t want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: %s: got %h expected %h", $time, what, got, want);
    endtask

    task automatic set_idle_mode(int mode);
        case (mode)
            0: begin
                send_idle_pct = 18;
                recv_idle_pct = 78;
            end
            1: begin
                send_idle_pct = 78;
                recv_idle_pct = 18;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // send_item lowers valid only when a gap is taken, so back-to-back items keep it high
    task automatic send_item(cmd_t cmd, csr_addr_t addr, xword_t data, logic [1:0] priv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_csr_address     <= addr;
        s_write_data      <= data;
        s_privilege_level <= priv;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        expected_q.push_back(predict_csr_result(cmd, addr, data, priv));
    endtask

    task automatic send_random_item();
        int   sel;
        cmd_t cmd;
        sel = $urandom_range(0, 19);
        cmd = (sel < 8) ? CMD_READ : (sel < 15) ? CMD_WRITE : (sel < 19) ? CMD_PEND : CMD_NONE;
        send_item(cmd, pick_address(), pick_word(), 2'($urandom_range(0, 3)));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
    endtask

    // only called with the block idle
    task automatic write_delegation(xword_t mdel, xword_t sdel);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIDELEG;
        cfg_wdata <= mdel;
        @(posedge aclk);
        cfg_index <= CFG_SIDELEG;
        cfg_wdata <= sdel;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        mdeleg_cfg = mdel;
        sdeleg_cfg = sdel;
    endtask

    task automatic test_reset_and_special_addresses();
        set_idle_mode(0);
        send_item(CMD_READ, ADDR_MISA, '0, PRIV_MACHINE);
        send_item(CMD_READ, ADDR_MSTATUS, '0, PRIV_MACHINE);
        send_item(CMD_WRITE, ADDR_MSTATUS, '1, PRIV_MACHINE);
        send_item(CMD_READ, ADDR_MSTATUS, '0, PRIV_MACHINE);
        send_item(CMD_WRITE, ADDR_MIE, '1, PRIV_MACHINE);
        send_item(CMD_WRITE, ADDR_MISA, '0, PRIV_MACHINE);
        send_item(CMD_READ, ADDR_MISA, '1, PRIV_MACHINE);
        send_item(CMD_WRITE, {PMPCFG_BASE, 2'd3}, '1, PRIV_MACHINE);
        send_item(CMD_READ, {PMPCFG_BASE, 2'd0}, '0, PRIV_MACHINE);
        send_item(CMD_READ, {PMPADDR_BASE, 4'hf}, '0, PRIV_MACHINE);
        send_item(CMD_WRITE, ADDR_MHARTID, '1, PRIV_MACHINE);
        send_item(CMD_READ, ADDR_MHARTID, '0, PRIV_MACHINE);
        send_item(CMD_READ, ADDR_MEDELEG, '0, PRIV_MACHINE);
        send_item(CMD_WRITE, ADDR_MIDELEG, '1, PRIV_MACHINE);
        send_item(CMD_READ, csr_addr_t'('1), '0, PRIV_MACHINE);
        send_item(CMD_WRITE, csr_addr_t'('0), '1, PRIV_MACHINE);
        send_item(CMD_NONE, csr_addr_t'('1), '1, PRIV_MACHINE);
        // pends at every privilege, reserved level included
        send_item(CMD_PEND, ADDR_MSTATUS, '1, PRIV_USER);
        send_item(CMD_PEND, ADDR_MSTATUS, '0, 2'd1);
        send_item(CMD_PEND, ADDR_MSTATUS, '0, PRIV_SUPER);
        send_item(CMD_PEND, ADDR_MSTATUS, '0, PRIV_MACHINE);
        // machine level with global enable off takes nothing
        send_item(CMD_WRITE, ADDR_MSTATUS, '0, PRIV_MACHINE);
        send_item(CMD_PEND, ADDR_MSTATUS, '0, PRIV_MACHINE);
        send_item(CMD_WRITE, ADDR_MSCRATCH, '1, PRIV_MACHINE);
        send_item(CMD_READ, ADDR_MSCRATCH, '0, PRIV_MACHINE);
    endtask

    task automatic test_delegation_settings();
        xword_t mdel_set [5];
        xword_t sdel_set [5];
        mdel_set = '{'0, '1, '1, '0, {$urandom, $urandom}};
        sdel_set = '{'0, '0, '1, '1, {$urandom, $urandom}};
        for (int p = 0; p < 5; p++) begin
            drain_results();
            write_delegation(mdel_set[p], sdel_set[p]);
            set_idle_mode(p * 3 / 5);
            repeat (250) send_random_item();
        end
    endtask

    // the receiver stalls long enough for the block to fill and push back on the sender
    task automatic test_result_backpressure();
        drain_results();
        set_idle_mode(2);
        for (int r = 0; r < 3; r++) begin
            hold_len <= 40 + 20 * r;
            hold_req <= hold_req + 1;
            repeat (24) send_random_item();
            drain_results();
        end
    endtask

    task automatic test_mixed_traffic();
        for (int m = 0; m < 3; m++) begin
            drain_results();
            write_delegation({$urandom, $urandom}, {$urandom, $urandom});
            set_idle_mode(m);
            repeat (185) send_random_item();
        end
    endtask

    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // each result transfer is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", m_read_data, '0);
            end else begin
                oldest = expected_q.pop_front();
                if (m_read_data !== oldest.rdata)
                    report_mismatch("read_data", m_read_data, oldest.rdata);
                if (m_access_status !== oldest.status)
                    report_mismatch("access_status", xword_t'(m_access_status),
                                    xword_t'(oldest.status));
                if (m_interrupt_target !== oldest.target)
                    report_mismatch("interrupt_target", xword_t'(m_interrupt_target),
                                    xword_t'(oldest.target));
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_and_special_addresses();
        test_delegation_settings();
        test_result_backpressure();
        test_mixed_traffic();
        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #200000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
src/rmcsr_pkg.sv
src/riscv_machine_csr_file.sv
dv/testbench.sv
